@@ rtl/saic_pkg.sv @@
// shared types, codes and defaults for the set associative instruction cache
package saic_pkg;

    localparam int DEF_WAYS        = 4;
    localparam int DEF_SETS        = 16;
    localparam int DEF_BLOCK_WORDS = 4;
    localparam int DEF_TAG_W       = 24;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BEGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_END   = 1'b1;

    localparam logic [31:0] MAP_BEGIN_RST = 32'h8000_0000;
    localparam logic [31:0] MAP_END_RST   = 32'h8800_0000;

    // byte length of one refill word
    localparam logic [3:0] REFILL_LEN = 4'd4;

    localparam logic REQ_FETCH  = 1'b0;
    localparam logic REQ_REFILL = 1'b1;

    typedef enum logic [1:0] {
        KIND_INST   = 2'd0,
        KIND_BYPASS = 2'd1,
        KIND_REFILL = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] fetch_addr;
        logic [3:0]  access_len;
        logic [31:0] refill_data;
    } in_word_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [31:0] inst_word;
        logic [31:0] mem_addr;
        logic [3:0]  read_len;
        logic        in_range;
        logic        was_hit;
    } out_word_t;

endpackage

@@ rtl/saic_ram.sv @@
// generic simple dual port ram with registered read, new data on same address write
module saic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= (we && waddr == raddr) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/set_assoc_icache_lru.sv @@
// set associative instruction cache with true lru replacement and refill handling
//
//  channel   | ports                         | carries
//  ----------+-------------------------------+----------------------------------
//  input     | s_valid s_ready s_word        | fetch or refill word
//  result    | m_valid m_ready m_word        | instruction, bypass, refill, error
//  config    | cfg_we cfg_index cfg_wdata    | map_begin, map_end
//
// a word is taken in any cycle where the lookup stage is empty or moving on; the rams
// capture their reads at the accepting edge, the lookup runs in the next cycle and any
// result is registered into m_valid and m_word as the stage moves on. ram writes land
// on that edge, where a following word's read may be captured too, and the rams return
// the new data then. valid bits and lru init flags are cleared by reset, so there is no
// clearing pass. a held result stalls the lookup stage only for a word with a result.
module set_assoc_icache_lru
    import saic_pkg::*;
#(
    parameter int WAYS        = DEF_WAYS,
    parameter int SETS        = DEF_SETS,
    parameter int BLOCK_WORDS = DEF_BLOCK_WORDS,
    parameter int TAG_W       = DEF_TAG_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WORD_FIELD = $clog2(BLOCK_WORDS);
    localparam int SET_FIELD  = $clog2(SETS);
    localparam int WAY_FIELD  = $clog2(WAYS);
    localparam int OFF_BITS   = 2 + WORD_FIELD;
    localparam int WORD_W     = WORD_FIELD > 0 ? WORD_FIELD : 1;
    localparam int SET_W      = SET_FIELD > 0 ? SET_FIELD : 1;
    localparam int WAY_W      = WAY_FIELD > 0 ? WAY_FIELD : 1;
    localparam int RANK_W     = WAY_W;
    localparam int LRU_W      = WAYS * RANK_W;
    localparam int DATA_DEPTH = SETS * BLOCK_WORDS;
    localparam int DAW        = DATA_DEPTH > 1 ? $clog2(DATA_DEPTH) : 1;
    localparam logic [31:0] WORD_MASK = 32'((64'd1 << WORD_FIELD) - 64'd1);
    localparam logic [31:0] SET_MASK  = 32'((64'd1 << SET_FIELD) - 64'd1);
    localparam logic [31:0] OFF_MASK  = 32'((64'd1 << OFF_BITS) - 64'd1);

    function automatic logic [DAW-1:0] data_addr(input logic [SET_W-1:0] set_idx,
                                                 input logic [WORD_W-1:0] word_idx);
        int sum;
        sum = int'(set_idx) * BLOCK_WORDS + int'(word_idx);
        return DAW'(sum);
    endfunction

    function automatic logic [LRU_W-1:0] lru_reset_row();
        logic [LRU_W-1:0] row;
        row = '0;
        for (int w = 0; w < WAYS; w++) begin
            row[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
        return row;
    endfunction

    // most recent gets rank 0, those ahead of it move back by one
    function automatic logic [LRU_W-1:0] lru_touch(input logic [LRU_W-1:0] row,
                                                   input logic [WAY_W-1:0] way);
        logic [LRU_W-1:0]  res;
        logic [RANK_W-1:0] r;
        logic [RANK_W-1:0] cur;
        res = row;
        r = row[way*RANK_W +: RANK_W];
        for (int w = 0; w < WAYS; w++) begin
            cur = row[w*RANK_W +: RANK_W];
            if (WAY_W'(w) == way) begin
                res[w*RANK_W +: RANK_W] = '0;
            end else if (cur < r) begin
                res[w*RANK_W +: RANK_W] = cur + 1'b1;
            end
        end
        return res;
    endfunction

    // configuration
    logic [31:0] map_begin_reg;
    logic [31:0] map_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_begin_reg <= MAP_BEGIN_RST;
            map_end_reg   <= MAP_END_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAP_BEGIN: map_begin_reg <= cfg_wdata;
                CFG_MAP_END:   map_end_reg   <= cfg_wdata;
            endcase
        end
    end

    // address decode ahead of the ram reads
    logic                s_accept;
    logic [31:0]         s0_set_raw;
    logic [31:0]         s0_word_raw;
    logic [SET_W-1:0]    s0_set;
    logic [WORD_W-1:0]   s0_word;
    logic [TAG_W-1:0]    s0_tag;

    always_comb begin
        s0_set_raw  = (s_word.fetch_addr >> OFF_BITS) & SET_MASK;
        s0_word_raw = (s_word.fetch_addr >> 2) & WORD_MASK;
        if (s0_set_raw >= 32'(SETS)) begin
            s0_set_raw = s0_set_raw - 32'(SETS);
        end
        if (s0_word_raw >= 32'(BLOCK_WORDS)) begin
            s0_word_raw = s0_word_raw - 32'(BLOCK_WORDS);
        end
        s0_set  = SET_W'(s0_set_raw);
        s0_word = WORD_W'(s0_word_raw);
        s0_tag  = TAG_W'(64'(s_word.fetch_addr) >> (OFF_BITS + SET_FIELD));
    end

    // lookup stage registers
    logic                s1_valid_reg, s1_valid_next;
    in_word_t            s1_word_reg;
    logic [SET_W-1:0]    s1_set_reg;
    logic [WORD_W-1:0]   s1_word_idx_reg;
    logic [TAG_W-1:0]    s1_tag_reg;

    // refill state
    logic                busy_reg, busy_next;
    logic [SET_W-1:0]    rf_set_reg, rf_set_next;
    logic [WAY_W-1:0]    rf_way_reg, rf_way_next;
    logic [WORD_W-1:0]   rf_count_reg, rf_count_next;
    logic [WORD_W-1:0]   pend_word_reg, pend_word_next;
    logic [TAG_W-1:0]    pend_tag_reg, pend_tag_next;
    logic [31:0]         pend_data_reg, pend_data_next;

    logic [WAYS-1:0]     valid_reg [SETS];
    logic [SETS-1:0]     lru_init_reg;

    logic                m_valid_reg, m_valid_next;
    out_word_t           m_word_reg, m_word_next;

    // ram ports
    logic [TAG_W-1:0]    tag_rd [WAYS];
    logic [31:0]         data_rd [WAYS];
    logic [LRU_W-1:0]    lru_rd;
    logic [WAYS-1:0]     tag_we;
    logic [WAYS-1:0]     data_we;
    logic [DAW-1:0]      data_waddr;
    logic                lru_we;
    logic [LRU_W-1:0]    lru_wdata;

    // lookup logic
    logic                s1_adv;
    logic                s1_has_result;
    logic                s1_in_range;
    logic [WAYS-1:0]     valid_row;
    logic [WAYS-1:0]     hit_vec;
    logic                hit_any;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    victim;
    logic [LRU_W-1:0]    lru_cur;
    logic                refill_last;
    logic                valid_set;
    logic                valid_clr;

    generate
        for (genvar g = 0; g < WAYS; g++) begin : g_way
            saic_ram #(
                .WIDTH(TAG_W),
                .DEPTH(SETS)
            ) u_tag_ram (
                .aclk (aclk),
                .we   (tag_we[g]),
                .waddr(rf_set_reg),
                .wdata(pend_tag_reg),
                .re   (s_accept),
                .raddr(s0_set),
                .rdata(tag_rd[g])
            );

            saic_ram #(
                .WIDTH(32),
                .DEPTH(DATA_DEPTH)
            ) u_data_ram (
                .aclk (aclk),
                .we   (data_we[g]),
                .waddr(data_waddr),
                .wdata(s1_word_reg.refill_data),
                .re   (s_accept),
                .raddr(data_addr(s0_set, s0_word)),
                .rdata(data_rd[g])
            );
        end
    endgenerate

    saic_ram #(
        .WIDTH(LRU_W),
        .DEPTH(SETS)
    ) u_lru_ram (
        .aclk (aclk),
        .we   (lru_we),
        .waddr(s1_set_reg),
        .wdata(lru_wdata),
        .re   (s_accept),
        .raddr(s0_set),
        .rdata(lru_rd)
    );

    always_comb begin
        s1_in_range = (s1_word_reg.fetch_addr >= map_begin_reg) &&
                      (s1_word_reg.fetch_addr < map_end_reg);
        valid_row   = valid_reg[s1_set_reg];
        lru_cur     = lru_init_reg[s1_set_reg] ? lru_rd : lru_reset_row();

        hit_any = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = valid_row[w] && (tag_rd[w] == s1_tag_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // ranks form a permutation, so the oldest way holds the top rank
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (lru_cur[w*RANK_W +: RANK_W] == RANK_W'(WAYS - 1)) begin
                victim = WAY_W'(w);
            end
        end

        refill_last = rf_count_reg == WORD_W'(BLOCK_WORDS - 1);

        s1_has_result = s1_valid_reg &&
                        (s1_word_reg.req_type == REQ_FETCH || (busy_reg && refill_last));
        s1_adv   = s1_valid_reg && (!s1_has_result || !m_valid_reg || m_ready);
        s_accept = s_valid && s_ready;

        s1_valid_next  = s_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        busy_next      = busy_reg;
        rf_set_next    = rf_set_reg;
        rf_way_next    = rf_way_reg;
        rf_count_next  = rf_count_reg;
        pend_word_next = pend_word_reg;
        pend_tag_next  = pend_tag_reg;
        pend_data_next = pend_data_reg;
        tag_we         = '0;
        data_we        = '0;
        data_waddr     = data_addr(rf_set_reg, rf_count_reg);
        lru_we         = 1'b0;
        lru_wdata      = lru_cur;
        valid_set      = 1'b0;
        valid_clr      = 1'b0;

        m_word_next             = '0;
        m_word_next.result_kind = KIND_INST;
        m_valid_next            = m_valid_reg && !m_ready;

        if (s1_adv) begin
            if (s1_word_reg.req_type == REQ_REFILL) begin
                if (busy_reg) begin
                    data_we[rf_way_reg] = 1'b1;
                    if (rf_count_reg == pend_word_reg) begin
                        pend_data_next = s1_word_reg.refill_data;
                    end
                    if (refill_last) begin
                        tag_we[rf_way_reg]    = 1'b1;
                        valid_set             = 1'b1;
                        busy_next             = 1'b0;
                        rf_count_next         = '0;
                        m_valid_next          = 1'b1;
                        m_word_next.inst_word = (rf_count_reg == pend_word_reg) ?
                                                s1_word_reg.refill_data : pend_data_reg;
                        m_word_next.in_range  = 1'b1;
                    end else begin
                        rf_count_next = rf_count_reg + 1'b1;
                    end
                end
            end else begin
                m_valid_next         = 1'b1;
                m_word_next.in_range = s1_in_range;
                if (busy_reg) begin
                    m_word_next.result_kind = KIND_ERROR;
                end else if (!s1_in_range) begin
                    m_word_next.result_kind = KIND_BYPASS;
                    m_word_next.mem_addr    = s1_word_reg.fetch_addr;
                    m_word_next.read_len    = s1_word_reg.access_len;
                end else if (hit_any) begin
                    lru_we                = 1'b1;
                    lru_wdata             = lru_touch(lru_cur, hit_way);
                    m_word_next.inst_word = data_rd[hit_way];
                    m_word_next.was_hit   = 1'b1;
                end else begin
                    lru_we                  = 1'b1;
                    lru_wdata               = lru_touch(lru_cur, victim);
                    valid_clr               = 1'b1;
                    busy_next               = 1'b1;
                    rf_set_next             = s1_set_reg;
                    rf_way_next             = victim;
                    rf_count_next           = '0;
                    pend_word_next          = s1_word_idx_reg;
                    pend_tag_next           = s1_tag_reg;
                    m_word_next.result_kind = KIND_REFILL;
                    m_word_next.mem_addr    = s1_word_reg.fetch_addr & ~OFF_MASK;
                    m_word_next.read_len    = REFILL_LEN;
                end
            end
        end
    end

    assign s_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            rf_set_reg    <= '0;
            rf_way_reg    <= '0;
            rf_count_reg  <= '0;
            pend_word_reg <= '0;
            pend_tag_reg  <= '0;
            m_valid_reg   <= 1'b0;
            lru_init_reg  <= '0;
            for (int s = 0; s < SETS; s++) begin
                valid_reg[s] <= '0;
            end
        end else begin
            s1_valid_reg  <= s1_valid_next;
            busy_reg      <= busy_next;
            rf_set_reg    <= rf_set_next;
            rf_way_reg    <= rf_way_next;
            rf_count_reg  <= rf_count_next;
            pend_word_reg <= pend_word_next;
            pend_tag_reg  <= pend_tag_next;
            m_valid_reg   <= m_valid_next;
            if (lru_we) begin
                lru_init_reg[s1_set_reg] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[s1_set_reg][victim] <= 1'b0;
            end
            if (valid_set) begin
                valid_reg[rf_set_reg][rf_way_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_data_reg <= pend_data_next;
        if (s_accept) begin
            s1_word_reg     <= s_word;
            s1_set_reg      <= s0_set;
            s1_word_idx_reg <= s0_word;
            s1_tag_reg      <= s0_tag;
        end
        if (m_valid_next && (!m_valid_reg || m_ready)) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule
